// ----- hw/rtl/dcs_pkg.sv -----
package dcs_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int TOTAL_W         = 11;
  localparam int SUM_W           = 36;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KICK,
    ST_DIV,
    ST_MUL,
    ST_TAIL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_SERIES,
    MUL_SUM,
    MUL_TAIL
  } mul_op_t;

endpackage

// ----- hw/rtl/dcs_if.sv -----
interface dcs_in_if #(
  parameter int VALUE_WIDTH = dcs_pkg::VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface dcs_out_if ();
  logic                           valid;
  logic                           ready;
  logic [dcs_pkg::TOTAL_W-1:0]    divisor_total;
  logic [dcs_pkg::SUM_W-1:0]      divisor_sum_out;

  modport source (output valid, output divisor_total, output divisor_sum_out, input ready);
  modport sink (input valid, input divisor_total, input divisor_sum_out, output ready);
endinterface

// ----- hw/rtl/divisor_count_and_sum.sv -----
// Divisor count and divisor sum of one positive integer per beat, by trial
// division over candidates 2, 3, 4, ... while the candidate squared stays at
// or below the remaining cofactor. Each candidate costs one pass of a radix-2
// serial divider; every prime factor found adds one further divide and one
// serial multiply on a max(36, VALUE_WIDTH + 1)-bit multiplier. The worst
// case tries near 2^(VALUE_WIDTH/2) candidates. One item is worked at a time;
// a finished result sits in an output register, so the next value is taken
// while it waits. A value of zero returns zero for both fields. Count
// saturates at 2047 and sum at 2^36 - 1.
module divisor_count_and_sum #(
  parameter int VALUE_WIDTH = dcs_pkg::VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dcs_in_if.sink    in_ch,
  dcs_out_if.source out_ch
);

  localparam int PW   = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int EW   = $clog2(VALUE_WIDTH + 2);
  localparam int TW   = dcs_pkg::TOTAL_W;
  localparam int SW   = dcs_pkg::SUM_W;
  localparam int MB_W = (VALUE_WIDTH + 1 > SW) ? VALUE_WIDTH + 1 : SW;

  dcs_pkg::state_t  state_r;
  dcs_pkg::state_t  state_nxt;
  dcs_pkg::mul_op_t mop_r;
  dcs_pkg::mul_op_t mul_op;

  logic [VALUE_WIDTH-1:0] n_r;
  logic [PW-1:0]          p_r;
  logic [EW-1:0]          e_r;
  logic                   run_r;
  logic [TW-1:0]          cnt_r;
  logic [SW-1:0]          sum_r;
  logic [SW-1:0]          ser_r;

  logic          out_valid_r;
  logic [TW-1:0] out_total_r;
  logic [SW-1:0] out_sum_r;

  logic                   in_fire;
  logic                   out_load;
  logic                   div_start;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [PW-1:0]          div_rem;
  logic                   mul_start;
  logic                   mul_done;
  logic [SW-1:0]          mul_prod;
  logic [SW-1:0]          mul_a;
  logic [MB_W-1:0]        mul_b;

  logic             rem_zero;
  logic             p_over;
  logic             n_big;
  logic [EW-1:0]    cnt_fac;
  logic [TW+EW-1:0] cnt_prod;
  logic [TW-1:0]    cnt_sat;
  logic [SW-1:0]    prod_inc;

  assign in_fire = in_ch.valid && in_ch.ready;

  always_comb begin
    rem_zero = (div_rem == '0);
    p_over   = VALUE_WIDTH'(p_r) > div_quo;
    n_big    = n_r > VALUE_WIDTH'(1);
    cnt_fac  = (state_r == dcs_pkg::ST_TAIL) ? EW'(2) : e_r + EW'(1);
    cnt_prod = (TW+EW)'(cnt_r) * (TW+EW)'(cnt_fac);
    cnt_sat  = (cnt_prod > (TW+EW)'(dcs_pkg::TOTAL_MAX)) ? dcs_pkg::TOTAL_MAX
                                                        : cnt_prod[TW-1:0];
    prod_inc = (mul_prod == dcs_pkg::SUM_MAX) ? dcs_pkg::SUM_MAX : mul_prod + SW'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.value == '0) ? dcs_pkg::ST_DONE : dcs_pkg::ST_KICK;
        end
      end
      dcs_pkg::ST_KICK: state_nxt = dcs_pkg::ST_DIV;
      dcs_pkg::ST_DIV: begin
        if (div_done) begin
          if (run_r) begin
            state_nxt = dcs_pkg::ST_MUL;
          end else if (p_over) begin
            state_nxt = dcs_pkg::ST_TAIL;
          end else begin
            state_nxt = dcs_pkg::ST_KICK;
          end
        end
      end
      dcs_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = (mop_r == dcs_pkg::MUL_TAIL) ? dcs_pkg::ST_DONE : dcs_pkg::ST_KICK;
        end
      end
      dcs_pkg::ST_TAIL: state_nxt = n_big ? dcs_pkg::ST_MUL : dcs_pkg::ST_DONE;
      dcs_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = dcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state_r == dcs_pkg::ST_KICK);
    mul_start = 1'b0;
    mul_a     = sum_r;
    mul_b     = '0;
    mul_op    = dcs_pkg::MUL_SUM;
    out_load  = 1'b0;
    unique case (state_r)
      dcs_pkg::ST_DIV: begin
        mul_start = div_done && run_r;
        if (rem_zero) begin
          mul_a  = ser_r;
          mul_b  = MB_W'(p_r);
          mul_op = dcs_pkg::MUL_SERIES;
        end else begin
          mul_b  = MB_W'(ser_r);
        end
      end
      dcs_pkg::ST_TAIL: begin
        mul_start = n_big;
        mul_b     = MB_W'(n_r) + MB_W'(1);
        mul_op    = dcs_pkg::MUL_TAIL;
      end
      dcs_pkg::ST_DONE: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_total_r <= cnt_r;
      out_sum_r   <= sum_r;
    end
    if (mul_start) begin
      mop_r <= mul_op;
    end
    unique case (state_r)
      dcs_pkg::ST_IDLE: begin
        if (in_fire) begin
          n_r   <= in_ch.value;
          p_r   <= PW'(2);
          e_r   <= '0;
          run_r <= 1'b0;
          cnt_r <= (in_ch.value == '0) ? '0 : TW'(1);
          sum_r <= (in_ch.value == '0) ? '0 : SW'(1);
        end
      end
      dcs_pkg::ST_DIV: begin
        if (div_done) begin
          if (!run_r) begin
            if (!p_over) begin
              if (rem_zero) begin
                n_r   <= div_quo;
                e_r   <= EW'(1);
                run_r <= 1'b1;
                ser_r <= SW'(p_r) + SW'(1);
              end else begin
                p_r <= p_r + PW'(1);
              end
            end
          end else if (rem_zero) begin
            n_r <= div_quo;
            e_r <= e_r + EW'(1);
          end else begin
            cnt_r <= cnt_sat;
            run_r <= 1'b0;
          end
        end
      end
      dcs_pkg::ST_MUL: begin
        if (mul_done) begin
          unique case (mop_r)
            dcs_pkg::MUL_SERIES: ser_r <= prod_inc;
            dcs_pkg::MUL_SUM: begin
              sum_r <= mul_prod;
              p_r   <= p_r + PW'(1);
            end
            dcs_pkg::MUL_TAIL: sum_r <= mul_prod;
            default: ;
          endcase
        end
      end
      dcs_pkg::ST_TAIL: begin
        if (n_big) begin
          cnt_r <= cnt_sat;
        end
      end
      default: ;
    endcase
  end

  dcs_divider #(
    .DVD_W (VALUE_WIDTH),
    .DVS_W (PW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (n_r),
    .divisor   (p_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  dcs_multiplier #(
    .B_W (MB_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_a),
    .mplier  (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign in_ch.ready            = (state_r == dcs_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.divisor_total   = out_total_r;
  assign out_ch.divisor_sum_out = out_sum_r;

endmodule

// ----- hw/rtl/dcs_divider.sv -----
module dcs_divider #(
  parameter int DVD_W = dcs_pkg::VALUE_WIDTH_DEF,
  parameter int DVS_W = dcs_pkg::VALUE_WIDTH_DEF / 2 + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CW = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVD_W-1:0] quo_nxt;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= CW'(DVD_W - 1);
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- hw/rtl/dcs_multiplier.sv -----
module dcs_multiplier #(
  parameter int B_W = dcs_pkg::SUM_W
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [dcs_pkg::SUM_W-1:0] mcand,
  input  logic [B_W-1:0]            mplier,
  output logic                      done,
  output logic [dcs_pkg::SUM_W-1:0] product
);

  localparam int SW = dcs_pkg::SUM_W;
  localparam int CW = $clog2(B_W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] a_r;
  logic [B_W-1:0] b_r;
  logic [SW-1:0] acc_r;
  logic [SW-1:0] acc_nxt;
  logic [SW+1:0] step;

  // msb first: double, add, clamp at the sum ceiling
  always_comb begin
    step    = {1'b0, acc_r, 1'b0} + (b_r[B_W-1] ? {2'b00, a_r} : '0);
    acc_nxt = (step > (SW+2)'(dcs_pkg::SUM_MAX)) ? dcs_pkg::SUM_MAX : step[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= mcand;
      b_r   <= mplier;
      acc_r <= '0;
      cnt_r <= CW'(B_W - 1);
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[B_W-2:0], 1'b0};
      cnt_r <= cnt_r - CW'(1);
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ----- sim/dcs_checker.sv -----
module dcs_checker (
  input  logic clk,
  input  logic rst_n,
  dcs_in_if    in_ch,
  dcs_out_if   out_ch,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dcs_pkg::TOTAL_W-1:0] total;
    logic [dcs_pkg::SUM_W-1:0]   sum;
  } divisor_stats_t;

  divisor_stats_t expected_divs[$];
  int             mismatch_cnt;

  function automatic divisor_stats_t divisor_stats(input logic [31:0] value);
    longint unsigned rest;
    longint unsigned cand;
    longint unsigned count;
    longint unsigned sum;
    longint unsigned power;
    longint unsigned series;
    int unsigned     expo;
    divisor_stats_t  res;
    rest  = value;
    count = 1;
    sum   = 1;
    if (rest == 0) begin
      res.total = '0;
      res.sum   = '0;
      return res;
    end
    for (cand = 2; cand <= rest / cand; cand++) begin
      if (rest % cand == 0) begin
        expo   = 0;
        power  = 1;
        series = 1;
        while (rest % cand == 0) begin
          rest   = rest / cand;
          expo++;
          power  = power * cand;
          series = series + power;
        end
        count = count * (expo + 1);
        sum   = sum * series;
      end
    end
    if (rest > 1) begin
      count = count * 2;
      sum   = sum * (rest + 1);
    end
    res.total = (count > dcs_pkg::TOTAL_MAX) ? dcs_pkg::TOTAL_MAX
                                             : count[dcs_pkg::TOTAL_W-1:0];
    res.sum   = (sum > dcs_pkg::SUM_MAX) ? dcs_pkg::SUM_MAX : sum[dcs_pkg::SUM_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    divisor_stats_t exp_beat;
    int             new_errs;
    new_errs = 0;
    if (!rst_n) begin
      expected_divs.delete();
      mismatch_cnt = 0;
      errors      <= 0;
      outstanding <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_divs.push_back(divisor_stats(in_ch.value));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_divs.size() == 0) begin
          new_errs++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: unexpected beat total=%0d sum=%0d", $realtime,
                     out_ch.divisor_total, out_ch.divisor_sum_out);
          end
        end else begin
          exp_beat = expected_divs.pop_front();
          if (out_ch.divisor_total !== exp_beat.total ||
              out_ch.divisor_sum_out !== exp_beat.sum) begin
            new_errs++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch total exp=%0d got=%0d, sum exp=%0d got=%0d",
                       $realtime, exp_beat.total, out_ch.divisor_total,
                       exp_beat.sum, out_ch.divisor_sum_out);
            end
          end
        end
      end
      errors      <= errors + new_errs;
      outstanding <= expected_divs.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   errors;
  int   outstanding;
  int   in_idle_pct;
  int   out_idle_pct;

  dcs_in_if  in_ch ();
  dcs_out_if out_ch ();

  divisor_count_and_sum u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dcs_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= out_idle_pct);
  end

  // small primes only, so trial division ends near the square root of the
  // random seed factor and each item stays cheap
  function automatic logic [31:0] smooth_value();
    int unsigned     primes[11];
    longint unsigned v;
    longint unsigned p;
    int unsigned     steps;
    primes = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31};
    v      = $urandom_range(65535, 1);
    steps  = $urandom_range(40, 0);
    repeat (steps) begin
      p = primes[$urandom_range(10, 0)];
      if (v * p <= 64'hFFFF_FFFF) begin
        v = v * p;
      end
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 2) begin
      return '0;
    end else if (pick < 17) begin
      return $urandom_range(65535, 1);
    end
    return smooth_value();
  endfunction

  task automatic send_value(input logic [31:0] v);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin
    logic [31:0] directed[$];
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd6, 32'd12, 32'd49, 32'd97,
                 32'd63001, 32'd65521, 32'd131042, 32'd65536, 32'h8000_0000,
                 32'hFFFF_FFFF, 32'hFFFE_0001, 32'd735134400, 32'd3491888400,
                 32'd2095133040, 32'd3486784401, 32'hFFFF_0000, 32'h5555_5555,
                 32'hAAAA_AAAA};
    in_idle_pct  = 13;
    out_idle_pct = 69;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);
    repeat (27) send_value(random_value());

    in_idle_pct  = 69;
    out_idle_pct = 13;
    repeat (25) send_value(random_value());

    in_idle_pct  = 0;
    out_idle_pct = 0;
    repeat (25) send_value(random_value());
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
